FILE: sv/vector_distance_accumulator_assert.svh
// ----------------------------------------------------------------------------
// vector distance accumulator assertion macros
// shared property forms for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef VECTOR_DISTANCE_ACCUMULATOR_ASSERT_SVH
`define VECTOR_DISTANCE_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define VDA_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define VDA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/vda_pkg.sv
// ----------------------------------------------------------------------------
// vda_pkg
// shared types and constants of the vector distance accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package vda_pkg;

    // width of both running sums and of the result
    localparam int SUM_BITS = 42;

    // result queue between accumulator and result stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

    // distance modes
    localparam logic [1:0] FUNC_SQ_L2 = 2'd0;
    localparam logic [1:0] FUNC_DOT   = 2'd1;
    localparam logic [1:0] FUNC_ROOT  = 2'd2;

    // one finished vector on its way to the result stage
    typedef struct packed {
        logic [SUM_BITS-1:0] value;
        logic                do_sqrt;
        logic                too_long;
    } vda_entry_t;

endpackage

`default_nettype wire

FILE: sv/vector_distance_accumulator.sv
// ----------------------------------------------------------------------------
// vector_distance_accumulator
// squared L2 distance, dot product or Euclidean distance of streamed vectors
// ----------------------------------------------------------------------------
// two vectors stream in one element pair per request, the pair in tdata and
// the mode in tuser, with tlast on the final pair; the mode is taken from
// that final request only (0 squared L2, 1 plain dot product without
// normalization, 2 floor integer square root of the squared L2, 3 acts as 0).
// the front accepts one pair every clock while tready is high; a product
// stage and a saturating 42-bit accumulate stage follow. finished vectors
// wait in a 4-entry queue for the result stage. squared L2 and dot results
// leave the queue straight into the output register once it is free; a
// Euclidean result leaves the queue into a shift-subtract square root (one
// root bit per cycle) and then waits until the output register is free.
// the intake holds tready low only when the queue has no room for another
// finished vector, so short vectors in Euclidean mode are limited by the
// square root, while long vectors stream at one pair per cycle as long as
// results are taken. pairs past MAX_DIM add nothing and raise too_long on
// that vector's result; both sums saturate at the 42-bit signed limits.
`default_nettype none

`include "vector_distance_accumulator_assert.svh"

module vector_distance_accumulator #(
    parameter int MAX_DIM   = 256,
    parameter int ELEM_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // first_elem, second_elem, zero fill to whole bytes
    input  wire logic [((2*ELEM_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // func
    input  wire logic [1:0]                            s_axis_tuser,
    input  wire logic                                  s_axis_tlast,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // distance, zero fill to whole bytes
    output logic [((vda_pkg::SUM_BITS+7)/8)*8-1:0]     m_axis_tdata,
    // too_long
    output logic                                       m_axis_tuser
);
    import vda_pkg::*;

    localparam int OUT_W = ((SUM_BITS + 7) / 8) * 8;

    logic                   q_push;
    logic                   q_pop;
    logic                   q_empty;
    logic [QUEUE_LVL_W-1:0] q_level;
    vda_entry_t             q_in;
    vda_entry_t             q_out;
    logic [SUM_BITS-1:0]    distance;

    // intake, length check and accumulation
    vda_front #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .in_first  (s_axis_tdata[ELEM_BITS-1:0]),
        .in_second (s_axis_tdata[2*ELEM_BITS-1:ELEM_BITS]),
        .in_last   (s_axis_tlast),
        .q_level   (q_level),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // finished vectors
    vda_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty),
        .level     (q_level)
    );

    // square root and output register
    vda_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (q_out),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_distance (distance),
        .out_too_long (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W'(distance);

    // the queue never takes a vector it has no room for
    `VDA_ASSERT_IMPLY(a_queue_no_overrun, q_push && !q_pop, q_level < QUEUE_LVL_W'(QUEUE_DEPTH), "result queue overrun")
    // the result stage never reads an empty queue
    `VDA_ASSERT_IMPLY(a_queue_no_underrun, q_pop, !q_empty, "result queue underrun")
    // intake only stalls when finished vectors are backed up
    `VDA_ASSERT_IMPLY(a_stall_has_cause, !s_axis_tready, q_level != '0, "intake stalled with empty queue")

endmodule

`default_nettype wire

FILE: sv/vda_front.sv
// ----------------------------------------------------------------------------
// vda_front
// element intake, length check, products and saturating accumulation
// ----------------------------------------------------------------------------
`default_nettype none

module vda_front #(
    parameter int MAX_DIM   = 256,
    parameter int ELEM_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      in_func,
    input  wire logic [ELEM_BITS-1:0]            in_first,
    input  wire logic [ELEM_BITS-1:0]            in_second,
    input  wire logic                            in_last,
    input  wire logic [vda_pkg::QUEUE_LVL_W-1:0] q_level,
    output logic                                 q_push,
    output vda_pkg::vda_entry_t                  q_data
);
    import vda_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int SQ_W  = 2 * ELEM_BITS + 2;
    localparam int DOT_W = 2 * ELEM_BITS;
    localparam int WIDE  = ((SQ_W > SUM_BITS) ? SQ_W : SUM_BITS) + 1;

    logic                  accept;
    logic                  in_room;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ovf_reg, ovf_next;

    logic signed [ELEM_BITS-1:0] a_s, b_s;
    logic signed [ELEM_BITS:0]   diff_s;
    logic signed [SQ_W-1:0]      sq_term;
    logic signed [DOT_W-1:0]     dot_term;

    logic                        s1_valid_reg;
    logic                        s1_last_reg;
    logic [1:0]                  s1_func_reg;
    logic                        s1_ovf_reg;
    logic signed [SQ_W-1:0]      s1_sq_reg;
    logic signed [DOT_W-1:0]     s1_dot_reg;

    logic signed [SUM_BITS-1:0]  sq_sum_reg, sq_sum_next;
    logic signed [SUM_BITS-1:0]  dot_sum_reg, dot_sum_next;
    logic signed [WIDE-1:0]      sq_wide, dot_wide;
    logic signed [SUM_BITS-1:0]  sq_sat, dot_sat;

    // room for the last request in flight as well as this one
    assign in_room  = ({1'b0, q_level} + {{QUEUE_LVL_W{1'b0}}, s1_valid_reg & s1_last_reg})
                      < (QUEUE_LVL_W + 1)'(QUEUE_DEPTH);
    assign in_ready = in_room;
    assign accept   = in_valid & in_ready;

    assign a_s      = signed'(in_first);
    assign b_s      = signed'(in_second);
    assign diff_s   = (ELEM_BITS + 1)'(a_s) - (ELEM_BITS + 1)'(b_s);
    assign sq_term  = SQ_W'(diff_s) * SQ_W'(diff_s);
    assign dot_term = DOT_W'(a_s) * DOT_W'(b_s);

    // element count and excess flag
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (in_last)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else if (count_reg < CNT_W'(MAX_DIM))
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            s1_valid_reg <= accept;
        end
    end

    // product stage, excess elements add nothing
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= in_last;
            s1_func_reg <= in_func;
            s1_ovf_reg  <= ovf_reg | (count_reg >= CNT_W'(MAX_DIM));
            if (count_reg < CNT_W'(MAX_DIM))
            begin
                s1_sq_reg  <= sq_term;
                s1_dot_reg <= dot_term;
            end
            else
            begin
                s1_sq_reg  <= '0;
                s1_dot_reg <= '0;
            end
        end
    end

    // saturating sums
    assign sq_wide  = WIDE'(sq_sum_reg) + WIDE'(s1_sq_reg);
    assign dot_wide = WIDE'(dot_sum_reg) + WIDE'(s1_dot_reg);

    always_comb
    begin
        if ((&sq_wide[WIDE-1:SUM_BITS-1]) || (~|sq_wide[WIDE-1:SUM_BITS-1]))
            sq_sat = sq_wide[SUM_BITS-1:0];
        else if (sq_wide[WIDE-1])
            sq_sat = {1'b1, {(SUM_BITS-1){1'b0}}};
        else
            sq_sat = {1'b0, {(SUM_BITS-1){1'b1}}};

        if ((&dot_wide[WIDE-1:SUM_BITS-1]) || (~|dot_wide[WIDE-1:SUM_BITS-1]))
            dot_sat = dot_wide[SUM_BITS-1:0];
        else if (dot_wide[WIDE-1])
            dot_sat = {1'b1, {(SUM_BITS-1){1'b0}}};
        else
            dot_sat = {1'b0, {(SUM_BITS-1){1'b1}}};
    end

    always_comb
    begin
        sq_sum_next  = sq_sum_reg;
        dot_sum_next = dot_sum_reg;
        q_push       = 1'b0;
        q_data.value    = (s1_func_reg == FUNC_DOT) ? dot_sat : sq_sat;
        q_data.do_sqrt  = (s1_func_reg == FUNC_ROOT);
        q_data.too_long = s1_ovf_reg;
        if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                q_push       = 1'b1;
                sq_sum_next  = '0;
                dot_sum_next = '0;
            end
            else
            begin
                sq_sum_next  = sq_sat;
                dot_sum_next = dot_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_sum_reg  <= '0;
            dot_sum_reg <= '0;
        end
        else
        begin
            sq_sum_reg  <= sq_sum_next;
            dot_sum_reg <= dot_sum_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/vda_queue.sv
// ----------------------------------------------------------------------------
// vda_queue
// short queue of finished vectors between accumulator and result stage
// ----------------------------------------------------------------------------
`default_nettype none

module vda_queue (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    input  wire vda_pkg::vda_entry_t             push_data,
    input  wire logic                            pop,
    output vda_pkg::vda_entry_t                  pop_data,
    output logic                                 empty,
    output logic [vda_pkg::QUEUE_LVL_W-1:0]      level
);
    import vda_pkg::*;

    vda_entry_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_LVL_W-1:0] level_reg;

    assign level    = level_reg;
    assign empty    = (level_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                level_reg <= level_reg + 1'b1;
            else if (pop && !push)
                level_reg <= level_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: sv/vda_back.sv
// ----------------------------------------------------------------------------
// vda_back
// result stage: optional shift-subtract square root and output register
// ----------------------------------------------------------------------------
`default_nettype none

module vda_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire vda_pkg::vda_entry_t           q_data,
    input  wire logic                          q_empty,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [vda_pkg::SUM_BITS-1:0]       out_distance,
    output logic                               out_too_long
);
    import vda_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_ROOT = 3'b010,
        B_DONE = 3'b100
    } back_state_t;

    // highest even bit position of the sum
    localparam int ROOT_TOP = ((SUM_BITS - 1) / 2) * 2;

    back_state_t           state_reg, state_next;
    logic [SUM_BITS-1:0]   rem_reg, rem_next;
    logic [SUM_BITS-1:0]   root_reg, root_next;
    logic [SUM_BITS-1:0]   bit_reg, bit_next;
    logic                  flag_reg, flag_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SUM_BITS-1:0]   out_data_reg, out_data_next;
    logic                  out_flag_reg, out_flag_next;
    logic                  out_free;
    logic [SUM_BITS-1:0]   trial;
    logic [SUM_BITS:0]     rem_diff;

    assign out_valid    = out_valid_reg;
    assign out_distance = out_data_reg;
    assign out_too_long = out_flag_reg;
    assign out_free     = !out_valid_reg || out_ready;

    assign trial    = root_reg + bit_reg;
    assign rem_diff = {1'b0, rem_reg} - {1'b0, trial};

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        out_flag_next  = out_flag_reg;
        q_pop          = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_data.do_sqrt)
                    begin
                        q_pop      = 1'b1;
                        rem_next   = q_data.value;
                        root_next  = '0;
                        bit_next   = SUM_BITS'(1) << ROOT_TOP;
                        flag_next  = q_data.too_long;
                        state_next = B_ROOT;
                    end
                    else if (out_free)
                    begin
                        q_pop          = 1'b1;
                        out_valid_next = 1'b1;
                        out_data_next  = q_data.value;
                        out_flag_next  = q_data.too_long;
                    end
                end
            end
            B_ROOT:
            begin
                // one result bit per cycle
                if (!rem_diff[SUM_BITS])
                begin
                    rem_next  = rem_diff[SUM_BITS-1:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                    state_next = B_DONE;
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = root_reg;
                    out_flag_next  = flag_reg;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        flag_reg     <= flag_next;
        out_data_reg <= out_data_next;
        out_flag_reg <= out_flag_next;
    end

endmodule

`default_nettype wire
